>>> src/serial_boot_loader_receiver_assert.svh
// assertion macros for the serial boot loader receiver checker
// expects signals named clk and rst in the scope of use
`ifndef SERIAL_BOOT_LOADER_RECEIVER_ASSERT_SVH
`define SERIAL_BOOT_LOADER_RECEIVER_ASSERT_SVH

// same-cycle implication
`define SBL_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sbl assertion failed");

// next-cycle implication
`define SBL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sbl assertion failed");

`endif

>>> src/sbl_pkg.sv
// shared types, constants and crc function of the serial boot loader receiver
// no dependencies
package sbl_pkg;

  typedef enum logic [2:0] {
    PH_START, PH_SIZE, PH_CKSUM, PH_ACK, PH_DATA, PH_EOT, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    OP_HDR, OP_ABORT, OP_MEM, OP_JUMP
  } op_t;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_MEM   = 2'd1,
    KIND_JUMP  = 2'd2,
    KIND_ABORT = 2'd3
  } kind_t;

  // command from front to back; mem write: w0 address, w1 data
  // header echo: w0 start word, w1 size crc, w2 checksum
  typedef struct packed {
    op_t         op;
    logic        ack;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
  } cmd_t;

  typedef struct packed {
    logic [31:0] load_base;
    logic [31:0] address_limit;
    logic [31:0] ack_code;
    logic [31:0] nak_code;
    logic [31:0] eot_code;
  } cfg_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_LOAD_BASE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_CODE      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NAK_CODE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_EOT_CODE      = 3'd4;

  localparam logic [31:0] RST_LOAD_BASE     = 32'h0000_8000;
  localparam logic [31:0] RST_ADDRESS_LIMIT = 32'h2000_0000;
  localparam logic [31:0] RST_ACK_CODE      = 32'd1;
  localparam logic [31:0] RST_NAK_CODE      = 32'd2;
  localparam logic [31:0] RST_EOT_CODE      = 32'd3;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [3:0] HDR_LAST_STEP = 4'd11;
  localparam logic [3:0] TAIL_STEP     = 4'd4;

  localparam int unsigned OUT_DATA_W = 72;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
    return 8'(w >> {sel, 3'b000});
  endfunction

endpackage

>>> src/sbl_queue.sv
// command queue between the front and back parts
// depends on sbl_pkg
module sbl_queue
  import sbl_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/sbl_front.sv
// front part: takes received bytes, builds words, runs the crcs and the
// protocol phases, and queues one command per word that needs results
// depends on sbl_pkg
module sbl_front
  import sbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  phase_t      phase;
  phase_t      phase_next;
  logic [1:0]  byte_position;
  logic [23:0] partial_word;
  logic [31:0] start_word;
  logic [31:0] program_size;
  logic [31:0] expected_crc;
  logic [31:0] size_crc;
  logic [31:0] running_crc;
  logic [31:0] bytes_loaded;
  logic [31:0] write_address;

  logic        fire;
  logic        active;
  logic        word_done;
  logic [31:0] word;
  logic [31:0] loaded_next;
  logic        in_range;
  logic        over_limit;
  logic        abort_hit;

  assign in_ready    = !q_full;
  assign fire        = in_valid && in_ready;
  assign active      = fire && (phase != PH_DONE);
  assign word_done   = (byte_position == 2'd3);
  assign word        = {in_data, partial_word};
  assign loaded_next = bytes_loaded + 32'd4;
  assign in_range    = (bytes_loaded + {30'd0, byte_position}) < program_size;
  assign over_limit  = (cfg.load_base + program_size) >= cfg.address_limit;
  assign abort_hit   = word_done &&
                       (((phase == PH_CKSUM) && over_limit) ||
                        ((phase == PH_ACK) && (word != cfg.ack_code)) ||
                        ((phase == PH_EOT) && ((word != cfg.eot_code) ||
                                               (expected_crc != ~running_crc))));

  always_comb begin
    phase_next = phase;
    if (active && word_done) begin
      if (abort_hit) begin
        phase_next = PH_START;
      end else begin
        case (phase)
          PH_START: phase_next = PH_SIZE;
          PH_SIZE:  phase_next = PH_CKSUM;
          PH_CKSUM: phase_next = PH_ACK;
          PH_ACK:   phase_next = (program_size == '0) ? PH_EOT : PH_DATA;
          PH_DATA:  phase_next = (loaded_next >= program_size) ? PH_EOT : PH_DATA;
          PH_EOT:   phase_next = PH_DONE;
          default:  phase_next = PH_DONE;
        endcase
      end
    end
  end

  always_comb begin
    push   = 1'b0;
    cmd.op = OP_ABORT;
    cmd.ack = 1'b0;
    cmd.w0 = '0;
    cmd.w1 = '0;
    cmd.w2 = '0;
    if (active && word_done) begin
      if (abort_hit) begin
        push = 1'b1;
      end else begin
        case (phase)
          PH_CKSUM: begin
            push   = 1'b1;
            cmd.op = OP_HDR;
            cmd.w0 = start_word;
            cmd.w1 = ~size_crc;
            cmd.w2 = word;
          end
          PH_DATA: begin
            push    = 1'b1;
            cmd.op  = OP_MEM;
            cmd.w0  = write_address;
            cmd.w1  = word;
            cmd.ack = ((program_size[7:0] - loaded_next[7:0]) == 8'd0);
          end
          PH_EOT: begin
            push   = 1'b1;
            cmd.op = OP_JUMP;
          end
          default: push = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (active && abort_hit)) begin
      phase         <= PH_START;
      byte_position <= '0;
      partial_word  <= '0;
      start_word    <= '0;
      program_size  <= '0;
      expected_crc  <= '0;
      size_crc      <= CRC_INIT;
      running_crc   <= CRC_INIT;
      bytes_loaded  <= '0;
      write_address <= '0;
    end else if (active) begin
      phase <= phase_next;
      if (phase == PH_SIZE) begin
        size_crc <= crc_byte(size_crc, in_data);
      end
      if ((phase == PH_DATA) && in_range) begin
        running_crc <= crc_byte(running_crc, in_data);
      end
      if (!word_done) begin
        partial_word  <= partial_word | (24'(in_data) << {byte_position, 3'b000});
        byte_position <= byte_position + 2'd1;
      end else begin
        partial_word  <= '0;
        byte_position <= '0;
        case (phase)
          PH_START: start_word   <= word;
          PH_SIZE:  program_size <= word;
          PH_CKSUM: expected_crc <= word;
          PH_ACK: begin
            write_address <= cfg.load_base;
            bytes_loaded  <= '0;
          end
          PH_DATA: begin
            write_address <= write_address + 32'd4;
            bytes_loaded  <= loaded_next;
          end
          default: start_word <= start_word;
        endcase
      end
    end
  end

endmodule

>>> src/sbl_back.sv
// back part: expands queued commands into result items, one per cycle while
// commands are queued and the output is accepted, into an output register
// depends on sbl_pkg
module sbl_back
  import sbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  cmd_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [31:0] out_mem_address,
  output logic [31:0] out_mem_data,
  output logic        out_last
);

  logic [3:0]  step;
  logic        load;
  kind_t       r_kind;
  logic [7:0]  r_tx;
  logic [31:0] r_addr;
  logic [31:0] r_data;
  logic        r_last;
  logic [31:0] hdr_word;
  logic [1:0]  ack_sel;

  assign load    = !q_empty && (!out_valid || out_ready);
  assign pop     = load && r_last;
  assign ack_sel = 2'(step - 4'd1);

  always_comb begin
    case (step[3:2])
      2'd0:    hdr_word = head.w0;
      2'd1:    hdr_word = head.w1;
      default: hdr_word = head.w2;
    endcase
  end

  always_comb begin
    r_kind = KIND_TX;
    r_tx   = '0;
    r_addr = '0;
    r_data = '0;
    r_last = 1'b0;
    case (head.op)
      OP_HDR: begin
        r_tx   = word_byte(hdr_word, step[1:0]);
        r_last = (step == HDR_LAST_STEP);
      end
      OP_ABORT: begin
        if (step == TAIL_STEP) begin
          r_kind = KIND_ABORT;
          r_last = 1'b1;
        end else begin
          r_tx = word_byte(cfg.nak_code, step[1:0]);
        end
      end
      OP_MEM: begin
        if (step == '0) begin
          r_kind = KIND_MEM;
          r_addr = head.w0;
          r_data = head.w1;
          r_last = !head.ack;
        end else begin
          r_tx   = word_byte(cfg.ack_code, ack_sel);
          r_last = (step == TAIL_STEP);
        end
      end
      OP_JUMP: begin
        if (step == TAIL_STEP) begin
          r_kind = KIND_JUMP;
          r_addr = cfg.load_base;
          r_last = 1'b1;
        end else begin
          r_tx = word_byte(cfg.ack_code, step[1:0]);
        end
      end
      default: r_last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= r_last ? 4'd0 : step + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind        <= r_kind;
      out_tx_byte     <= r_tx;
      out_mem_address <= r_addr;
      out_mem_data    <= r_data;
      out_last        <= r_last;
    end
  end

endmodule

>>> src/serial_boot_loader_receiver.sv
// Serial boot loader receiver. Takes one received byte per cycle on the
// s_axis side while the command queue has room; a byte that completes a word
// may queue one command, which the result sequencer expands into 1 to 12
// result items at one item per cycle, while m_axis_tready accepts them,
// through a registered output. The sustained rate is set by the result
// sequencer: 12 items for the header echo, 5 for a data word with
// acknowledge, 1 for a plain data word. The queue holds QueueDepth commands
// so that reception keeps going while results drain. Configuration registers
// are written through cfg_wr_en, cfg_index and cfg_data; the user must write
// them only while the block is idle, which the block itself does not enforce.
// depends on sbl_pkg, sbl_front, sbl_queue, sbl_back
module serial_boot_loader_receiver
  import sbl_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // rx_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // tx_byte, mem_address, mem_data
  output logic [1:0]             m_axis_tuser,  // kind
  output logic                   m_axis_tlast,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  cfg_t        cfg;
  logic        push;
  cmd_t        push_cmd;
  logic        q_full;
  logic        q_empty;
  logic        pop;
  cmd_t        head;
  logic [7:0]  tx_byte;
  logic [31:0] mem_address;
  logic [31:0] mem_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.load_base     <= RST_LOAD_BASE;
      cfg.address_limit <= RST_ADDRESS_LIMIT;
      cfg.ack_code      <= RST_ACK_CODE;
      cfg.nak_code      <= RST_NAK_CODE;
      cfg.eot_code      <= RST_EOT_CODE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOAD_BASE:     cfg.load_base     <= cfg_data;
        REG_ADDRESS_LIMIT: cfg.address_limit <= cfg_data;
        REG_ACK_CODE:      cfg.ack_code      <= cfg_data;
        REG_NAK_CODE:      cfg.nak_code      <= cfg_data;
        REG_EOT_CODE:      cfg.eot_code      <= cfg_data;
        default:           cfg.eot_code      <= cfg.eot_code;
      endcase
    end
  end

  sbl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  sbl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  sbl_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_kind        (m_axis_tuser),
    .out_tx_byte     (tx_byte),
    .out_mem_address (mem_address),
    .out_mem_data    (mem_data),
    .out_last        (m_axis_tlast)
  );

  assign m_axis_tdata = {mem_data, mem_address, tx_byte};

endmodule

>>> src/sbl_checker.sv
// port-level checks on the result stream of the serial boot loader receiver
// depends on sbl_pkg and serial_boot_loader_receiver_assert.svh; bound to the top
`include "serial_boot_loader_receiver_assert.svh"

module sbl_checker
  import sbl_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]            m_axis_tuser,
  input logic                  m_axis_tlast
);

  `SBL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  `SBL_ASSERT_NOW(a_final_kinds_last, m_axis_tvalid && (m_axis_tuser == KIND_JUMP || m_axis_tuser == KIND_ABORT), m_axis_tlast)
  `SBL_ASSERT_NOW(a_tx_only_byte, m_axis_tvalid && m_axis_tuser == KIND_TX, m_axis_tdata[OUT_DATA_W-1:8] == '0)
  `SBL_ASSERT_NOW(a_no_byte_else, m_axis_tvalid && m_axis_tuser != KIND_TX, m_axis_tdata[7:0] == 8'd0)

endmodule

bind serial_boot_loader_receiver sbl_checker u_sbl_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
